// ----- src/playfair_digraph_encryptor_top_assert.svh -----
// Assertion macros shared by the Playfair encryptor modules.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_TOP_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pfe_pkg.sv -----
// Shared types, constants and helper functions for the Playfair encryptor.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LETTER_I    = 5'd8;
    localparam letter_t LETTER_J    = 5'd9;
    localparam letter_t LETTER_X    = 5'd23;
    localparam letter_t LETTER_LAST = letter_t'(LETTERS - 1);
    localparam cell_t   CELL_COUNT  = cell_t'(CELLS);

    typedef enum logic [1:0] {
        KIND_KEY      = 2'd0,
        KIND_KEY_DONE = 2'd1,
        KIND_TEXT     = 2'd2,
        KIND_END      = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOK_A,
        ST_LOOK_B,
        ST_CALC,
        ST_SQ_X,
        ST_SQ_Y,
        ST_EMIT_X,
        ST_EMIT_Y
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic fill_step;
        logic look_a;
        logic look_b;
        logic calc;
        logic sq_x;
        logic sq_y;
        logic emit_x;
        logic emit_y;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic start_fill;
        logic start_pair;
        logic fill_last;
        logic out_free;
    } dp_status_t;

    function automatic letter_t fold_j(input letter_t c);
        fold_j = (c == LETTER_J) ? LETTER_I : c;
    endfunction

    function automatic coord_t cell_row(input cell_t c);
        coord_t r;
        r = '0;
        for (int i = 1; i < SIDE; i++) begin
            if (int'(c) >= i * SIDE) r = coord_t'(i);
        end
        cell_row = r;
    endfunction

    function automatic coord_t cell_col(input cell_t c);
        cell_col = coord_t'(int'(c) - SIDE * int'(cell_row(c)));
    endfunction

    function automatic cell_t cell_at(input coord_t row, input coord_t col);
        cell_at = cell_t'(SIDE * int'(row) + int'(col));
    endfunction

    function automatic coord_t wrap_inc(input coord_t v);
        wrap_inc = (int'(v) == SIDE - 1) ? '0 : coord_t'(v + 3'd1);
    endfunction

endpackage

`default_nettype wire

// ----- src/pfe_ctrl.sv -----
// Control state machine sequencing key fill and digraph encryption.
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_digraph_encryptor_top_assert.svh"

module pfe_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire pfe_pkg::dp_status_t st,
    output pfe_pkg::ctl_cmd_t       cmd
);

    pfe_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pfe_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    if (st.start_fill) begin
                        state_next = pfe_pkg::ST_FILL;
                    end else if (st.start_pair) begin
                        state_next = pfe_pkg::ST_LOOK_A;
                    end
                end
            end
            pfe_pkg::ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (st.fill_last) state_next = pfe_pkg::ST_IDLE;
            end
            pfe_pkg::ST_LOOK_A: begin
                cmd.look_a = 1'b1;
                state_next = pfe_pkg::ST_LOOK_B;
            end
            pfe_pkg::ST_LOOK_B: begin
                cmd.look_b = 1'b1;
                state_next = pfe_pkg::ST_CALC;
            end
            pfe_pkg::ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = pfe_pkg::ST_SQ_X;
            end
            pfe_pkg::ST_SQ_X: begin
                cmd.sq_x   = 1'b1;
                state_next = pfe_pkg::ST_SQ_Y;
            end
            pfe_pkg::ST_SQ_Y: begin
                cmd.sq_y   = 1'b1;
                state_next = pfe_pkg::ST_EMIT_X;
            end
            pfe_pkg::ST_EMIT_X: begin
                if (st.out_free) begin
                    cmd.emit_x = 1'b1;
                    state_next = pfe_pkg::ST_EMIT_Y;
                end
            end
            pfe_pkg::ST_EMIT_Y: begin
                if (st.out_free) begin
                    cmd.emit_y = 1'b1;
                    state_next = pfe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    // the fill sweep runs to its last letter before anything else happens
    `PFE_ASSERT_NEXT(a_fill_holds, aclk, aresetn,
        (state_reg == pfe_pkg::ST_FILL) && !st.fill_last,
        state_reg == pfe_pkg::ST_FILL, "fill sweep left early")

endmodule

`default_nettype wire

// ----- src/pfe_datapath.sv -----
// Datapath: key square memories, pairing state, lookup and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_digraph_encryptor_top_assert.svh"

module pfe_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         s_tdata,
    input  wire logic [1:0]         s_tuser,
    output logic [7:0]              m_tdata,
    output logic                    m_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire logic               cfg_wr_en,
    input  wire logic [4:0]         cfg_wr_data,
    input  wire pfe_pkg::ctl_cmd_t  cmd,
    output pfe_pkg::dp_status_t     st
);

    // memories
    pfe_pkg::letter_t square_mem [pfe_pkg::CELLS];
    pfe_pkg::cell_t   cell_mem   [pfe_pkg::LETTERS];

    pfe_pkg::letter_t        filler_reg;
    logic [pfe_pkg::LETTERS-1:0] letter_used_reg;
    pfe_pkg::cell_t          fill_count_reg;
    pfe_pkg::letter_t        fill_k_reg;
    pfe_pkg::letter_t        pending_reg;
    logic                    pending_valid_reg;
    pfe_pkg::letter_t        a_reg, b_reg;
    pfe_pkg::cell_t          cell_rd_reg, ca_reg, cb_reg;
    pfe_pkg::letter_t        sq_rd_reg, x_reg;
    logic                    out_valid_reg;
    pfe_pkg::letter_t        out_letter_reg;
    logic                    out_last_reg;

    pfe_pkg::kind_t   kind;
    pfe_pkg::letter_t in_letter, folded, filler_cur, b_pick;
    logic             letter_ok, complete, text_pair, end_pair;
    logic             place_en, place_do;
    pfe_pkg::letter_t place_letter;
    pfe_pkg::letter_t cell_rd_addr;
    pfe_pkg::coord_t  ra, ka, rb, kb;
    pfe_pkg::cell_t   x_addr, y_addr, sq_rd_addr;

    // ---------------- input decode ----------------
    assign kind      = pfe_pkg::kind_t'(s_tuser);
    assign in_letter = s_tdata[4:0];
    assign letter_ok = (in_letter <= pfe_pkg::LETTER_LAST);
    assign folded    = pfe_pkg::fold_j(in_letter);
    assign complete  = (fill_count_reg == pfe_pkg::CELL_COUNT);
    assign filler_cur = (filler_reg > pfe_pkg::LETTER_LAST) ? pfe_pkg::LETTER_X
                                                            : pfe_pkg::fold_j(filler_reg);

    assign text_pair = (kind == pfe_pkg::KIND_TEXT) && complete && letter_ok
                       && pending_valid_reg;
    assign end_pair  = (kind == pfe_pkg::KIND_END) && complete && pending_valid_reg;
    // doubled letter or end of text pairs with the filler
    assign b_pick    = (text_pair && (folded != pending_reg)) ? folded : filler_cur;

    assign st.start_fill = (kind == pfe_pkg::KIND_KEY_DONE) && !complete;
    assign st.start_pair = text_pair || end_pair;
    assign st.fill_last  = (fill_k_reg == pfe_pkg::LETTER_LAST);
    assign st.out_free   = !out_valid_reg || m_tready;

    // ---------------- square placement ----------------
    always_comb begin
        place_en     = 1'b0;
        place_letter = folded;
        if (cmd.fill_step) begin
            place_en     = (fill_k_reg != pfe_pkg::LETTER_J);
            place_letter = fill_k_reg;
        end else if (cmd.accept) begin
            place_en     = (kind == pfe_pkg::KIND_KEY) && letter_ok && !complete;
            place_letter = folded;
        end
    end

    assign place_do = place_en && !complete && !letter_used_reg[place_letter];

    always_ff @(posedge aclk) begin
        if (place_do) begin
            square_mem[fill_count_reg] <= place_letter;
            cell_mem[place_letter]     <= fill_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filler_reg        <= pfe_pkg::LETTER_X;
            letter_used_reg   <= '0;
            fill_count_reg    <= '0;
            fill_k_reg        <= '0;
            pending_reg       <= '0;
            pending_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) filler_reg <= cfg_wr_data;
            if (place_do) begin
                letter_used_reg[place_letter] <= 1'b1;
                fill_count_reg <= pfe_pkg::cell_t'(fill_count_reg + 5'd1);
            end
            if (cmd.fill_step) begin
                fill_k_reg <= pfe_pkg::letter_t'(fill_k_reg + 5'd1);
            end else if (cmd.accept) begin
                fill_k_reg <= '0;
            end
            if (cmd.accept) begin
                if ((kind == pfe_pkg::KIND_TEXT) && complete && letter_ok) begin
                    if (!pending_valid_reg) begin
                        pending_reg       <= folded;
                        pending_valid_reg <= 1'b1;
                    end else if (folded != pending_reg) begin
                        pending_valid_reg <= 1'b0;
                    end
                end else if (end_pair) begin
                    pending_valid_reg <= 1'b0;
                end
            end
        end
    end

    // ---------------- pair lookup ----------------
    always_ff @(posedge aclk) begin
        if (cmd.accept && st.start_pair) begin
            a_reg <= pending_reg;
            b_reg <= b_pick;
        end
    end

    assign cell_rd_addr = cmd.look_a ? a_reg : b_reg;

    always_ff @(posedge aclk) begin
        if (cmd.look_a || cmd.look_b) cell_rd_reg <= cell_mem[cell_rd_addr];
        if (cmd.look_b) ca_reg <= cell_rd_reg;
        if (cmd.calc)   cb_reg <= cell_rd_reg;
    end

    assign ra = pfe_pkg::cell_row(ca_reg);
    assign ka = pfe_pkg::cell_col(ca_reg);
    assign rb = pfe_pkg::cell_row(cb_reg);
    assign kb = pfe_pkg::cell_col(cb_reg);

    always_comb begin
        if (ra == rb) begin
            x_addr = pfe_pkg::cell_at(ra, pfe_pkg::wrap_inc(ka));
            y_addr = pfe_pkg::cell_at(rb, pfe_pkg::wrap_inc(kb));
        end else if (ka == kb) begin
            x_addr = pfe_pkg::cell_at(pfe_pkg::wrap_inc(ra), ka);
            y_addr = pfe_pkg::cell_at(pfe_pkg::wrap_inc(rb), kb);
        end else begin
            x_addr = pfe_pkg::cell_at(ra, kb);
            y_addr = pfe_pkg::cell_at(rb, ka);
        end
    end

    assign sq_rd_addr = cmd.sq_y ? y_addr : x_addr;

    always_ff @(posedge aclk) begin
        if (cmd.sq_x || cmd.sq_y) sq_rd_reg <= square_mem[sq_rd_addr];
        if (cmd.sq_y) x_reg <= sq_rd_reg;
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_x || cmd.emit_y) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_x) begin
            out_letter_reg <= x_reg;
            out_last_reg   <= 1'b0;
        end else if (cmd.emit_y) begin
            out_letter_reg <= sq_rd_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_letter_reg};
    assign m_tlast  = out_last_reg;

    `PFE_ASSERT_NOW(a_emit_free, aclk, aresetn,
        cmd.emit_x || cmd.emit_y, !out_valid_reg || m_tready,
        "item loaded over an untaken result")
    `PFE_ASSERT_NOW(a_used_count, aclk, aresetn,
        1'b1, $countones(letter_used_reg) == int'(fill_count_reg),
        "used letters and fill count disagree")
    `PFE_ASSERT_NOW(a_pair_complete, aclk, aresetn,
        cmd.look_a, complete, "pair lookup before square complete")

endmodule

`default_nettype wire

// ----- src/playfair_digraph_encryptor_top.sv -----
// Top level of the Playfair digraph encryptor: controller plus datapath.
// Key letters and text letters without result are absorbed while idle. Key complete: the fill
//   sweep steps through the alphabet, one letter per cycle through the single square write port.
// Pair: states LOOK_A, LOOK_B, CALC, SQ_X, SQ_Y, EMIT_X, EMIT_Y in order: two cell reads,
//   two square reads, two loads; a busy output stalls the loads. No new item until both are loaded.
// Reset: aresetn synchronous, active low; clears square fill, pending letter, filler=X.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_encryptor_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input items
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [4:0] letter, [7:5] zero
    input  wire logic [1:0] s_tuser,   // [1:0] kind
    // result items
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [4:0] cipher_letter, [7:5] zero
    output logic            m_tlast,   // second letter of a digraph
    // filler letter register
    input  wire logic       cfg_wr_en,
    input  wire logic [4:0] cfg_wr_data
);

    pfe_pkg::ctl_cmd_t   cmd;
    pfe_pkg::dp_status_t st;

    // Controller: sequences fill sweep, two cell lookups, two square reads,
    // and the two output loads. Ready only while idle.
    pfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: square and letter-position memories, pairing state and
    // an output register so a new item is taken while a result waits.
    pfe_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

`default_nettype wire
